[rtl/core/pca_pkg.sv]
`default_nettype none
package pca_pkg;

	localparam int PALETTE_ENTRIES_DEF = 256;
	localparam int QUEUE_DEPTH = 2;

	localparam int POS_W   = 12;
	localparam int COLOR_W = 32;
	localparam int DIM_W   = 13;
	localparam int STAT_W  = 2;
	localparam int IDX_W   = 8;
	localparam int CH6_W   = 6;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = DIM_W;

	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 1'd1;

	localparam logic [DIM_W-1:0] SCREEN_WIDTH_RST  = 13'd320;
	localparam logic [DIM_W-1:0] SCREEN_HEIGHT_RST = 13'd240;

	localparam logic [STAT_W-1:0] ST_DRAWN        = 2'd0;
	localparam logic [STAT_W-1:0] ST_OFF_SCREEN   = 2'd1;
	localparam logic [STAT_W-1:0] ST_PALETTE_FULL = 2'd2;

	// pixel after screen classification, as held in the queue
	typedef struct packed {
		logic [POS_W-1:0]   pos_x;
		logic [POS_W-1:0]   pos_y;
		logic [COLOR_W-1:0] pixel_color;
		logic               off_screen;
	} pix_item_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [IDX_W-1:0]  palette_index;
		logic              is_new_entry;
		logic [CH6_W-1:0]  red6;
		logic [CH6_W-1:0]  green6;
		logic [CH6_W-1:0]  blue6;
		logic [POS_W-1:0]  draw_x;
		logic [POS_W-1:0]  draw_y;
	} result_t;

	typedef struct packed {
		logic      valid;
		pix_item_t item;
	} queue_head_t;

endpackage
`default_nettype wire

[rtl/core/pca_pix_if.sv]
`default_nettype none
interface pca_pix_if;
	import pca_pkg::*;

	logic               valid;
	logic               ready;
	logic [POS_W-1:0]   pos_x;
	logic [POS_W-1:0]   pos_y;
	logic [COLOR_W-1:0] pixel_color;

	modport source (output valid, output pos_x, output pos_y, output pixel_color,
		input ready);
	modport sink (input valid, input pos_x, input pos_y, input pixel_color,
		output ready);
endinterface
`default_nettype wire

[rtl/core/pca_res_if.sv]
`default_nettype none
interface pca_res_if;
	import pca_pkg::*;

	logic              valid;
	logic              ready;
	logic [STAT_W-1:0] status;
	logic [IDX_W-1:0]  palette_index;
	logic              is_new_entry;
	logic [CH6_W-1:0]  red6;
	logic [CH6_W-1:0]  green6;
	logic [CH6_W-1:0]  blue6;
	logic [POS_W-1:0]  draw_x;
	logic [POS_W-1:0]  draw_y;

	modport source (output valid, output status, output palette_index,
		output is_new_entry, output red6, output green6, output blue6,
		output draw_x, output draw_y, input ready);
	modport sink (input valid, input status, input palette_index,
		input is_new_entry, input red6, input green6, input blue6,
		input draw_x, input draw_y, output ready);
endinterface
`default_nettype wire

[rtl/core/palette_color_allocator.sv]
// Palette color allocator.
// Input channel pix carries one pixel per transaction: pos_x, pos_y and a
// 32-bit pixel_color. Output channel res returns exactly one result per pixel,
// in order: status (drawn, off screen, palette full), palette_index,
// is_new_entry, the three channels cut to 6 bits, and the coordinates.
// The front checks the pixel against screen_width / screen_height (config
// indexes 0 and 1, written through cfg_we/cfg_index/cfg_data; the user must
// see they are written only while idle, which the block does not enforce)
// and drops it into a two-entry queue. The back walks the palette memory one
// slot per cycle through its single registered read port, lowest slot first,
// and appends the color on a miss while the palette has room. The back
// handles one pixel at a time; the queue keeps taking new pixels meanwhile.
// Reset clears the fill count and the screen size returns to 320 x 240; the
// palette contents need no clearing. A stalled receiver holds the result in
// the output register; the back finishes its next pixel and then waits, and
// the queue keeps taking pixels until full, after which pix.ready drops.
`default_nettype none
module palette_color_allocator #(
	parameter int PALETTE_ENTRIES = pca_pkg::PALETTE_ENTRIES_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [pca_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [pca_pkg::CFG_DATA_W-1:0] cfg_data,
	pca_pix_if.sink                             pix,
	pca_res_if.source                           res
);
	import pca_pkg::*;

	logic        q_full;
	logic        q_push;
	logic        q_pop;
	pix_item_t   q_push_item;
	queue_head_t q_head;

	// classify and hold screen size
	pca_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.pix         (pix),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_push_item (q_push_item)
	);

	// decouple intake from the palette search
	pca_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (q_push_item),
		.full      (q_full),
		.pop       (q_pop),
		.head      (q_head)
	);

	// search, allocate and register the result
	pca_back #(
		.PALETTE_ENTRIES (PALETTE_ENTRIES)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (q_head),
		.pop    (q_pop),
		.res    (res)
	);
endmodule
`default_nettype wire

[rtl/core/pca_front.sv]
`default_nettype none
module pca_front (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [pca_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [pca_pkg::CFG_DATA_W-1:0] cfg_data,
	pca_pix_if.sink                            pix,
	input  wire logic                          q_full,
	output logic                               q_push,
	output pca_pkg::pix_item_t                 q_push_item
);
	import pca_pkg::*;

	logic [DIM_W-1:0] screen_width_q;
	logic [DIM_W-1:0] screen_height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_width_q  <= SCREEN_WIDTH_RST;
			screen_height_q <= SCREEN_HEIGHT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SCREEN_WIDTH:  screen_width_q  <= cfg_data;
				REG_SCREEN_HEIGHT: screen_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign pix.ready = !q_full;
	assign q_push    = pix.valid && !q_full;

	always_comb begin
		q_push_item.pos_x       = pix.pos_x;
		q_push_item.pos_y       = pix.pos_y;
		q_push_item.pixel_color = pix.pixel_color;
		q_push_item.off_screen  = ({1'b0, pix.pos_x} >= screen_width_q) ||
			({1'b0, pix.pos_y} >= screen_height_q);
	end
endmodule
`default_nettype wire

[rtl/core/pca_queue.sv]
`default_nettype none
module pca_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire pca_pkg::pix_item_t push_item,
	output logic                full,
	input  wire logic           pop,
	output pca_pkg::queue_head_t head
);
	import pca_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	pix_item_t        slots_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full       = (count_q == CNT_W'(QUEUE_DEPTH));
	assign head.valid = (count_q != '0);
	assign head.item  = slots_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head.valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end
endmodule
`default_nettype wire

[rtl/core/pca_back.sv]
`default_nettype none
module pca_back #(
	parameter int PALETTE_ENTRIES = pca_pkg::PALETTE_ENTRIES_DEF
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire pca_pkg::queue_head_t head,
	output logic                 pop,
	pca_res_if.source            res
);
	import pca_pkg::*;

	localparam int IW = $clog2(PALETTE_ENTRIES);
	localparam int CW = $clog2(PALETTE_ENTRIES + 1);

	typedef enum logic [2:0] {
		S_IDLE   = 3'b001,
		S_SEARCH = 3'b010,
		S_FINISH = 3'b100
	} state_t;

	state_t           state_q;
	pix_item_t        cur_q;
	logic [CW-1:0]    used_q;
	logic [CW-1:0]    issue_cnt_q;
	logic             rd_vld_q;
	logic [IW-1:0]    rd_idx_q;
	logic [COLOR_W-1:0] rd_data_q;
	logic             found_q;
	logic [IW-1:0]    slot_q;
	logic             out_valid_q;
	result_t          res_q;

	logic [COLOR_W-1:0] palette_mem [PALETTE_ENTRIES];

	logic          issue;
	logic          hit;
	logic          miss;
	logic          room;
	logic          out_free;
	logic          load;
	logic          append;
	logic          drawn;
	logic [IW-1:0] fin_slot;
	logic [IW+7:0] slot_ext;
	result_t       res_d;

	always_comb begin
		pop      = (state_q == S_IDLE) && head.valid;
		hit      = (state_q == S_SEARCH) && rd_vld_q && (rd_data_q == cur_q.pixel_color);
		issue    = (state_q == S_SEARCH) && (issue_cnt_q < used_q) && !hit;
		miss     = (state_q == S_SEARCH) && !rd_vld_q && (issue_cnt_q >= used_q);
		room     = used_q < CW'(PALETTE_ENTRIES);
		out_free = !out_valid_q || res.ready;
		load     = (state_q == S_FINISH) && out_free;
		append   = load && !cur_q.off_screen && !found_q && room;
		drawn    = !cur_q.off_screen && (found_q || room);
		fin_slot = found_q ? slot_q : used_q[IW-1:0];
		slot_ext = {8'b0, fin_slot};

		res_d        = '0;
		res_d.draw_x = cur_q.pos_x;
		res_d.draw_y = cur_q.pos_y;
		if (cur_q.off_screen) begin
			res_d.status = ST_OFF_SCREEN;
		end else if (!drawn) begin
			res_d.status = ST_PALETTE_FULL;
		end else begin
			res_d.status        = ST_DRAWN;
			res_d.palette_index = slot_ext[7:0];
			res_d.is_new_entry  = !found_q;
			res_d.red6          = cur_q.pixel_color[23:18];
			res_d.green6        = cur_q.pixel_color[15:10];
			res_d.blue6         = cur_q.pixel_color[7:2];
		end
	end

	// palette storage: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (append) begin
			palette_mem[used_q[IW-1:0]] <= cur_q.pixel_color;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			rd_data_q <= palette_mem[issue_cnt_q[IW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			used_q      <= '0;
			issue_cnt_q <= '0;
			rd_vld_q    <= 1'b0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
			if (append) begin
				used_q <= used_q + CW'(1);
			end
			case (state_q)
				S_IDLE: begin
					if (pop) begin
						issue_cnt_q <= '0;
						rd_vld_q    <= 1'b0;
						found_q     <= 1'b0;
						state_q     <= head.item.off_screen ? S_FINISH : S_SEARCH;
					end
				end
				S_SEARCH: begin
					rd_vld_q <= issue;
					if (issue) begin
						issue_cnt_q <= issue_cnt_q + CW'(1);
					end
					if (hit) begin
						found_q <= 1'b1;
						state_q <= S_FINISH;
					end else if (miss) begin
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head.item;
		end
		if (issue) begin
			rd_idx_q <= issue_cnt_q[IW-1:0];
		end
		if (hit) begin
			slot_q <= rd_idx_q;
		end
		if (load) begin
			res_q <= res_d;
		end
	end

	assign res.valid         = out_valid_q;
	assign res.status        = res_q.status;
	assign res.palette_index = res_q.palette_index;
	assign res.is_new_entry  = res_q.is_new_entry;
	assign res.red6          = res_q.red6;
	assign res.green6        = res_q.green6;
	assign res.blue6         = res_q.blue6;
	assign res.draw_x        = res_q.draw_x;
	assign res.draw_y        = res_q.draw_y;

	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= CW'(PALETTE_ENTRIES))
		else $error("palette fill count beyond table size");

	a_append_grows: assert property (@(posedge clk) disable iff (!arst_n)
		append |=> used_q == $past(used_q) + CW'(1))
		else $error("new palette entry did not advance fill count");

	a_hit_in_use: assert property (@(posedge clk) disable iff (!arst_n)
		hit |-> CW'(rd_idx_q) < used_q)
		else $error("match reported on a slot not in use");

	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> state_q != S_IDLE)
		else $error("queue pop did not start item processing");
endmodule
`default_nettype wire
